// ===== hw/rtl/rphb_pkg.sv =====
`timescale 1ns / 1ps

package rphb_pkg;

    localparam int CFG_AW = 5;
    localparam int DIV_STEPS = 8;
    localparam int DIV_CW = $clog2(DIV_STEPS + 1);

    localparam int unsigned GUARD_BAND_DEF = 100;
    localparam int unsigned TIMEOUT_TICKS_DEF = 50;

    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_TEMP = 2'd2;

    localparam logic [1:0] WANT_UNINIT = 2'd0;
    localparam logic [1:0] WANT_FWD    = 2'd1;
    localparam logic [1:0] WANT_BWD    = 2'd2;
    localparam logic [1:0] WANT_BRAKE  = 2'd3;

    localparam logic [1:0] BR_FWD   = 2'd0;
    localparam logic [1:0] BR_BWD   = 2'd1;
    localparam logic [1:0] BR_BRAKE = 2'd2;

    localparam logic [1:0] HEAT_COOL = 2'd0;
    localparam logic [1:0] HEAT_WARM = 2'd1;
    localparam logic [1:0] HEAT_HOT  = 2'd2;

    localparam logic [2:0] REG_PULSE_LOW  = 3'd0;
    localparam logic [2:0] REG_PULSE_HIGH = 3'd1;
    localparam logic [2:0] REG_DEAD_BAND  = 3'd2;
    localparam logic [2:0] REG_FULL_BAND  = 3'd3;
    localparam logic [2:0] REG_SLEW_STEP  = 3'd4;
    localparam logic [2:0] REG_MODE_BITS  = 3'd5;
    localparam logic [2:0] REG_HOT_LEVEL  = 3'd6;
    localparam logic [2:0] REG_WARM_LEVEL = 3'd7;

    localparam logic [15:0] PULSE_LOW_RST  = 16'd1000;
    localparam logic [15:0] PULSE_HIGH_RST = 16'd2000;
    localparam logic [7:0]  DEAD_BAND_RST  = 8'd20;
    localparam logic [7:0]  FULL_BAND_RST  = 8'd20;
    localparam logic [7:0]  SLEW_STEP_RST  = 8'd2;
    localparam logic [1:0]  MODE_BITS_RST  = 2'd0;
    localparam logic [7:0]  HOT_LEVEL_RST  = 8'd60;
    localparam logic [7:0]  WARM_LEVEL_RST = 8'd90;

    localparam logic [7:0] DUTY_FULL  = 8'd255;
    localparam logic [7:0] DUTY_WARM  = 8'd128;
    localparam logic [7:0] DUTY_LOW   = 8'd10;
    localparam logic [7:0] GOOD_CAP   = 8'd15;
    localparam logic [7:0] GOOD_MIN   = 8'd10;

    typedef struct packed {
        logic [15:0] pulse_low;
        logic [15:0] pulse_high;
        logic [7:0]  dead_band;
        logic [7:0]  full_band;
        logic [7:0]  slew_step;
        logic [1:0]  mode_bits;
        logic [7:0]  hot_level;
        logic [7:0]  warm_level;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic square;
        logic finish;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== hw/rtl/rphb_regs.sv =====
`timescale 1ns / 1ps

module rphb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rphb_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rphb_pkg::cfg_t              cfg
);
    import rphb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[CFG_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_PULSE_LOW:  cfg_next.pulse_low  = pwdata[15:0];
                REG_PULSE_HIGH: cfg_next.pulse_high = pwdata[15:0];
                REG_DEAD_BAND:  cfg_next.dead_band  = pwdata[7:0];
                REG_FULL_BAND:  cfg_next.full_band  = pwdata[7:0];
                REG_SLEW_STEP:  cfg_next.slew_step  = pwdata[7:0];
                REG_MODE_BITS:  cfg_next.mode_bits  = pwdata[1:0];
                REG_HOT_LEVEL:  cfg_next.hot_level  = pwdata[7:0];
                REG_WARM_LEVEL: cfg_next.warm_level = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PULSE_LOW:  prdata = {16'd0, cfg_reg.pulse_low};
            REG_PULSE_HIGH: prdata = {16'd0, cfg_reg.pulse_high};
            REG_DEAD_BAND:  prdata = {24'd0, cfg_reg.dead_band};
            REG_FULL_BAND:  prdata = {24'd0, cfg_reg.full_band};
            REG_SLEW_STEP:  prdata = {24'd0, cfg_reg.slew_step};
            REG_MODE_BITS:  prdata = {30'd0, cfg_reg.mode_bits};
            REG_HOT_LEVEL:  prdata = {24'd0, cfg_reg.hot_level};
            REG_WARM_LEVEL: prdata = {24'd0, cfg_reg.warm_level};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_low  <= PULSE_LOW_RST;
            cfg_reg.pulse_high <= PULSE_HIGH_RST;
            cfg_reg.dead_band  <= DEAD_BAND_RST;
            cfg_reg.full_band  <= FULL_BAND_RST;
            cfg_reg.slew_step  <= SLEW_STEP_RST;
            cfg_reg.mode_bits  <= MODE_BITS_RST;
            cfg_reg.hot_level  <= HOT_LEVEL_RST;
            cfg_reg.warm_level <= WARM_LEVEL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/rphb_div.sv =====
`timescale 1ns / 1ps

module rphb_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [15:0]                    num,
    input  logic [15:0]                    den,
    output logic [rphb_pkg::DIV_STEPS-1:0] quot,
    output logic                           done
);
    import rphb_pkg::*;

    // The numerator is below the divisor, so each step yields one fraction bit.
    logic [DIV_CW-1:0]    cnt_reg, cnt_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          den_reg, den_next;
    logic [DIV_STEPS-1:0] quot_reg, quot_next;
    logic                 done_reg, done_next;
    logic [16:0]          trial;
    logic [16:0]          diff;
    logic                 fits;

    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign quot  = quot_reg;
    assign done  = done_reg;

    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next  = DIV_CW'(DIV_STEPS);
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? diff[15:0] : trial[15:0];
            quot_next = {quot_reg[DIV_STEPS-2:0], fits};
            cnt_next  = cnt_reg - DIV_CW'(1);
            done_next = (cnt_reg == DIV_CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

endmodule

// ===== hw/rtl/rphb_datapath.sv =====
`timescale 1ns / 1ps

module rphb_datapath #(
    parameter int unsigned GUARD_BAND    = rphb_pkg::GUARD_BAND_DEF,
    parameter int unsigned TIMEOUT_TICKS = rphb_pkg::TIMEOUT_TICKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rphb_pkg::cfg_t        cfg,
    input  rphb_pkg::ctrl_cmd_t   cmd,
    output rphb_pkg::dp_stat_t    stat,
    input  logic [1:0]            s_req_type,
    input  logic                  s_pin_level,
    input  logic [15:0]           s_edge_time,
    input  logic [7:0]            s_temp_sample,
    output logic [7:0]            m_duty,
    output logic [1:0]            m_bridge_dir,
    output logic [1:0]            m_wanted_dir,
    output logic [7:0]            m_goal_duty,
    output logic [1:0]            m_heat_level,
    output logic                  m_signal_ok
);
    import rphb_pkg::*;

    logic [1:0]  req_reg;
    logic        lvl_reg;
    logic [15:0] time_reg;
    logic [7:0]  temp_reg;

    logic [15:0] rise_reg, rise_next;
    logic [7:0]  good_reg, good_next;
    logic [5:0]  tout_reg, tout_next;
    logic [7:0]  goal_reg, goal_next;
    logic [1:0]  want_reg, want_next;
    logic [1:0]  bdir_reg, bdir_next;
    logic [7:0]  duty_reg, duty_next;
    logic [1:0]  heat_reg, heat_next;
    logic        sat_reg, sat_next;
    logic [7:0]  sq_reg, sq_next;

    logic [7:0]  o_duty_reg;
    logic [1:0]  o_bdir_reg;
    logic [1:0]  o_want_reg;
    logic [7:0]  o_goal_reg;
    logic [1:0]  o_heat_reg;
    logic        o_ok_reg;

    logic [15:0]        width;
    logic signed [17:0] ws, lo_s, hi_s, db_s, fb_s, gb_s, mid_s, num_s, den_s;
    logic [16:0]        mid_sum;
    logic               pulse_ok, in_dead, below, full_zone, den_pos, num_neg, sat;
    logic               map_go, need_div, warm_hit, good_hi;
    logic [7:0]         imm_duty, good_dec;
    logic [15:0]        div_num;
    logic [DIV_STEPS-1:0] quot;
    logic               div_done;
    logic [7:0]         dq;
    logic [15:0]        prod;

    logic [1:0]  want_tick, as_req;
    logic [8:0]  dps, dms;

    assign width   = time_reg - rise_reg;
    assign ws      = $signed({2'b00, width});
    assign lo_s    = $signed({2'b00, cfg.pulse_low});
    assign hi_s    = $signed({2'b00, cfg.pulse_high});
    assign db_s    = $signed({10'd0, cfg.dead_band});
    assign fb_s    = $signed({10'd0, cfg.full_band});
    assign gb_s    = $signed({10'd0, 8'(GUARD_BAND)});
    assign mid_sum = {1'b0, cfg.pulse_low} + {1'b0, cfg.pulse_high};
    assign mid_s   = $signed({2'b00, mid_sum[16:1]});

    assign good_hi   = good_reg > GOOD_MIN;
    assign pulse_ok  = (ws > lo_s - gb_s) && (ws < hi_s + gb_s) && (heat_reg != HEAT_HOT);
    assign in_dead   = (ws > mid_s - db_s) && (ws < mid_s + db_s);
    assign below     = ws < mid_s;
    assign full_zone = below ? (ws < lo_s + fb_s) : (ws > hi_s - fb_s);
    assign num_s     = below ? (mid_s - db_s - ws) : (ws - mid_s - db_s);
    assign den_s     = below ? (mid_s - db_s - lo_s) : (hi_s - mid_s - db_s);
    assign den_pos   = den_s > 18'sd0;
    assign num_neg   = num_s < 18'sd0;
    assign sat       = num_s >= den_s;

    assign map_go   = (req_reg == REQ_EDGE) && !lvl_reg && pulse_ok && good_hi && !in_dead;
    assign need_div = map_go && !full_zone && den_pos && !num_neg;
    assign imm_duty = (full_zone || !den_pos) ? DUTY_FULL : 8'd0;
    assign div_num  = sat ? 16'd0 : num_s[15:0];
    assign good_dec = (good_reg != 8'd0) ? good_reg - 8'd1 : 8'd0;

    assign warm_hit = cfg.mode_bits[1] && (heat_reg == HEAT_WARM) && (duty_reg > DUTY_WARM);

    assign stat.need_div = need_div;
    assign stat.div_done = div_done;

    rphb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.decode && need_div),
        .num     (div_num),
        .den     (den_s[15:0]),
        .quot    (quot),
        .done    (div_done)
    );

    assign dq   = sat_reg ? DUTY_FULL : quot;
    assign prod = dq * dq;

    assign want_tick = (tout_reg == 6'd0) ? WANT_BRAKE : want_reg;
    assign dps       = {1'b0, duty_reg} + {1'b0, cfg.slew_step};
    assign dms       = {1'b0, duty_reg} - {1'b0, cfg.slew_step};

    always_comb begin
        unique case (bdir_reg)
            BR_FWD:  as_req = WANT_FWD;
            BR_BWD:  as_req = WANT_BWD;
            default: as_req = WANT_BRAKE;
        endcase
    end

    always_comb begin
        rise_next = rise_reg;
        good_next = good_reg;
        tout_next = tout_reg;
        goal_next = goal_reg;
        want_next = want_reg;
        bdir_next = bdir_reg;
        duty_next = duty_reg;
        heat_next = heat_reg;
        sat_next  = sat_reg;
        sq_next   = sq_reg;
        if (cmd.decode) begin
            sat_next = sat;
            unique case (req_reg)
                REQ_EDGE: begin
                    if (lvl_reg) begin
                        rise_next = time_reg;
                    end else if (pulse_ok) begin
                        if (good_hi) begin
                            good_next = GOOD_CAP;
                            tout_next = 6'(TIMEOUT_TICKS);
                            if (in_dead) begin
                                goal_next = DUTY_FULL;
                                want_next = WANT_BRAKE;
                            end else begin
                                want_next = below ? WANT_BWD : WANT_FWD;
                                if (!need_div) begin
                                    goal_next = warm_hit ? DUTY_WARM : imm_duty;
                                end
                            end
                        end else begin
                            good_next = good_reg + 8'd1;
                        end
                    end else begin
                        good_next = good_dec;
                        if (good_dec < GOOD_MIN) begin
                            want_next = WANT_BRAKE;
                        end
                    end
                end
                REQ_TICK: begin
                    if (tout_reg != 6'd0) begin
                        tout_next = tout_reg - 6'd1;
                    end
                    want_next = want_tick;
                    if (as_req != want_tick) begin
                        priority if (want_tick == WANT_FWD && bdir_reg == BR_BRAKE) begin
                            duty_next = 8'd0;
                            bdir_next = BR_FWD;
                        end else if (want_tick == WANT_BWD && bdir_reg == BR_BRAKE) begin
                            duty_next = 8'd0;
                            bdir_next = BR_BWD;
                        end else if (duty_reg <= DUTY_LOW) begin
                            bdir_next = BR_BRAKE;
                            duty_next = DUTY_FULL;
                        end else begin
                            duty_next = (duty_reg > cfg.slew_step) ? dms[7:0] : 8'd0;
                        end
                    end else if (duty_reg != goal_reg) begin
                        priority if ({1'b0, goal_reg} > dps) begin
                            duty_next = dps[7:0];
                        end else if (duty_reg >= cfg.slew_step && goal_reg < dms[7:0]) begin
                            duty_next = dms[7:0];
                        end else begin
                            duty_next = goal_reg;
                        end
                    end
                end
                REQ_TEMP: begin
                    if (cfg.mode_bits[1]) begin
                        priority if (temp_reg < cfg.hot_level) begin
                            heat_next = HEAT_HOT;
                            want_next = WANT_BRAKE;
                        end else if (temp_reg < cfg.warm_level) begin
                            heat_next = HEAT_WARM;
                        end else begin
                            heat_next = HEAT_COOL;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.square) begin
            sq_next = cfg.mode_bits[0] ? prod[15:8] : dq;
        end
        if (cmd.finish) begin
            goal_next = warm_hit ? DUTY_WARM : sq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg <= 16'd0;
            good_reg <= 8'd0;
            tout_reg <= 6'(TIMEOUT_TICKS);
            goal_reg <= 8'd0;
            want_reg <= WANT_UNINIT;
            bdir_reg <= BR_BRAKE;
            duty_reg <= 8'd0;
            heat_reg <= HEAT_COOL;
        end else begin
            rise_reg <= rise_next;
            good_reg <= good_next;
            tout_reg <= tout_next;
            goal_reg <= goal_next;
            want_reg <= want_next;
            bdir_reg <= bdir_next;
            duty_reg <= duty_next;
            heat_reg <= heat_next;
        end
        sat_reg <= sat_next;
        sq_reg  <= sq_next;
        if (cmd.capture) begin
            req_reg  <= s_req_type;
            lvl_reg  <= s_pin_level;
            time_reg <= s_edge_time;
            temp_reg <= s_temp_sample;
        end
        if (cmd.out_load) begin
            o_duty_reg <= duty_reg;
            o_bdir_reg <= bdir_reg;
            o_want_reg <= want_reg;
            o_goal_reg <= goal_reg;
            o_heat_reg <= heat_reg;
            o_ok_reg   <= good_hi;
        end
    end

    assign m_duty       = o_duty_reg;
    assign m_bridge_dir = o_bdir_reg;
    assign m_wanted_dir = o_want_reg;
    assign m_goal_duty  = o_goal_reg;
    assign m_heat_level = o_heat_reg;
    assign m_signal_ok  = o_ok_reg;

endmodule

// ===== hw/rtl/rphb_ctrl.sv =====
`timescale 1ns / 1ps

module rphb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rphb_pkg::dp_stat_t   stat,
    output rphb_pkg::ctrl_cmd_t  cmd
);
    import rphb_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SQR    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign slot_free = !m_valid_reg || m_ready;

    assign cmd.capture  = s_valid && s_ready;
    assign cmd.decode   = (state_reg == ST_DECODE);
    assign cmd.square   = (state_reg == ST_SQR);
    assign cmd.finish   = (state_reg == ST_FIN);
    assign cmd.out_load = (state_reg == ST_OUT) && slot_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DECODE;
            ST_DECODE: state_next = stat.need_div ? ST_DIV : ST_OUT;
            ST_DIV:    if (stat.div_done) state_next = ST_SQR;
            ST_SQR:    state_next = ST_FIN;
            ST_FIN:    state_next = ST_OUT;
            ST_OUT:    if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted beat did not enter decode");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a beat not yet taken");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output state");

endmodule

// ===== hw/rtl/rc_pulse_hbridge_controller_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Beat
// s_       in   s_valid/s_ready    req_type, pin_level, edge_time, temp_sample
// m_       out  m_valid/m_ready    duty, bridge_dir, wanted_dir, goal_duty, heat_level, signal_ok
// apb      in   psel/penable       eight setting registers at 4*index, pready always high
//
// A falling edge whose new duty target needs the divider passes through accept, decode,
// the eight steps of the restoring divider and its registered done flag, one squaring
// multiply, one target write and the output load. Every other beat passes through accept,
// decode and output load. Reset is synchronous and active low; it restores the settings and
// the control and bridge state, but not the captured beat, the divide and square results or output data.
// A low m_ready keeps the result in the output register; the next result waits in the
// controller until the register is free, and no beat is accepted meanwhile.

module rc_pulse_hbridge_controller_top #(
    parameter int unsigned GUARD_BAND    = rphb_pkg::GUARD_BAND_DEF,
    parameter int unsigned TIMEOUT_TICKS = rphb_pkg::TIMEOUT_TICKS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rphb_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic                        s_pin_level,
    input  logic [15:0]                 s_edge_time,
    input  logic [7:0]                  s_temp_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_duty,
    output logic [1:0]                  m_bridge_dir,
    output logic [1:0]                  m_wanted_dir,
    output logic [7:0]                  m_goal_duty,
    output logic [1:0]                  m_heat_level,
    output logic                        m_signal_ok
);
    import rphb_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    rphb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rphb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rphb_datapath #(
        .GUARD_BAND    (GUARD_BAND),
        .TIMEOUT_TICKS (TIMEOUT_TICKS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .s_req_type    (s_req_type),
        .s_pin_level   (s_pin_level),
        .s_edge_time   (s_edge_time),
        .s_temp_sample (s_temp_sample),
        .m_duty        (m_duty),
        .m_bridge_dir  (m_bridge_dir),
        .m_wanted_dir  (m_wanted_dir),
        .m_goal_duty   (m_goal_duty),
        .m_heat_level  (m_heat_level),
        .m_signal_ok   (m_signal_ok)
    );

endmodule
